/* rtl/core/greedy_box_nms_unit_macros.svh */
// ----------------------------------------------------------------------------
// greedy_box_nms_unit assertion macros
// Concurrent check shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_UNIT_MACROS_SVH
`define GREEDY_BOX_NMS_UNIT_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("greedy_box_nms_unit: check failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("greedy_box_nms_unit: check failed");

`endif

/* rtl/core/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, defaults and register indexes of the box NMS unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 13;

    localparam int SIZE_W     = 12;
    localparam int AREA_W     = 24;
    localparam int THR_W      = 9;
    localparam int CAND_W     = 7;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CANDIDATES = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 9'd128;
    localparam logic [CAND_W-1:0] MAXC_RESET = 7'd64;
    localparam logic [CAND_W-1:0] SEEN_SAT   = 7'd127;

endpackage

`default_nettype wire

/* rtl/core/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/greedy_box_nms_unit.sv */
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy IoU non-maximum suppression over boxes sorted by falling score.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one candidate box per
//   transaction; frame_end marks the last candidate of a frame and clears the
//   kept list after its result. Output channel (out_valid/out_ready) returns
//   one result per input: keep, kept_slot and frame_done.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once;
//   the user must issue them only while the unit is idle (not enforced).
//   Flow: a dropped candidate or one facing an empty list goes from ST_AREA
//   straight to ST_DONE and the output register; otherwise the unit reads
//   every kept box in ST_SCAN, empties the compare pipeline in ST_DRAIN and
//   then loads the result in ST_DONE; a full list drops. The compare
//   pipeline takes one kept box per cycle from the list RAM. One candidate
//   is processed at a time; in_ready returns with out_valid.
//   The result sits in an output register: while the receiver stalls, the
//   unit holds it and accepts the next candidate, but cannot post a new
//   result until that one is taken.
//   Reset empties the kept list, clears the counters and returns the
//   registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_nms_unit
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] box_left,
    input  wire logic signed [COORD_BITS-1:0] box_top,
    input  wire logic        [SIZE_W-1:0]     box_width,
    input  wire logic        [SIZE_W-1:0]     box_height,
    input  wire logic                         frame_end,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              keep,
    output logic             [SLOT_W-1:0]     kept_slot,
    output logic                              frame_done
);

    localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KCW    = $clog2(MAX_KEPT + 1);
    localparam int EW     = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W + 1) + 1;
    localparam int INTER_W = 2 * SIZE_W;
    localparam int UNI_W  = AREA_W + 1;
    localparam int LHS_W  = INTER_W + 8;
    localparam int PROD_W = THR_W + UNI_W;
    localparam int OFF_H  = AREA_W;
    localparam int OFF_W  = OFF_H + SIZE_W;
    localparam int OFF_T  = OFF_W + SIZE_W;
    localparam int OFF_L  = OFF_T + COORD_BITS;
    localparam int RAM_W  = OFF_L + COORD_BITS;
    localparam int PIPE_N = 5;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AREA  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    function automatic logic [SIZE_W-1:0] overlap(
        input logic signed [COORD_BITS-1:0] a0,
        input logic        [SIZE_W-1:0]     alen,
        input logic signed [COORD_BITS-1:0] b0,
        input logic        [SIZE_W-1:0]     blen
    );
        logic signed [EW-1:0] a0x;
        logic signed [EW-1:0] b0x;
        logic signed [EW-1:0] ae;
        logic signed [EW-1:0] be;
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] d;
        a0x = EW'(a0);
        b0x = EW'(b0);
        ae  = a0x + $signed(EW'(alen));
        be  = b0x + $signed(EW'(blen));
        lo  = (a0x > b0x) ? a0x : b0x;
        hi  = (ae < be) ? ae : be;
        d   = hi - lo;
        return (hi > lo) ? d[SIZE_W-1:0] : '0;
    endfunction

    state_t state_reg, state_next;

    logic [THR_W-1:0]  iou_thr_reg;
    logic [CAND_W-1:0] max_cand_reg;
    logic [KCW-1:0]    kept_count_reg;
    logic [CAND_W-1:0] seen_count_reg;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              elig_reg;
    logic              supp_reg;
    logic [PIPE_N-1:0] pipe_v_reg;

    logic signed [COORD_BITS-1:0] c_left_reg;
    logic signed [COORD_BITS-1:0] c_top_reg;
    logic        [SIZE_W-1:0]     c_width_reg;
    logic        [SIZE_W-1:0]     c_height_reg;
    logic                         c_fend_reg;
    logic        [AREA_W-1:0]     c_area_reg;

    logic [RAM_W-1:0] rd_data;
    logic [RAM_W-1:0] wr_data;
    logic             issue;
    logic             last_issue;
    logic             load_out;
    logic             keep_next;
    logic             accept;

    logic signed [COORD_BITS-1:0] k_left;
    logic signed [COORD_BITS-1:0] k_top;
    logic        [SIZE_W-1:0]     k_width;
    logic        [SIZE_W-1:0]     k_height;
    logic        [AREA_W-1:0]     k_area;

    logic [SIZE_W-1:0]  ow_reg, oh_reg;
    logic [AREA_W-1:0]  ka1_reg, ka2_reg;
    logic [INTER_W-1:0] inter_reg, inter3_reg;
    logic [UNI_W-1:0]   uni_reg;
    logic [LHS_W-1:0]   lhs_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               zero_reg;

    logic              out_valid_reg;
    logic              keep_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              fdone_reg;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid & in_ready;
    assign issue      = (state_reg == ST_SCAN);
    assign last_issue = (KCW'(idx_reg) + KCW'(1)) == kept_count_reg;
    assign load_out   = (state_reg == ST_DONE) & (~out_valid_reg | out_ready);
    assign keep_next  = elig_reg & ~supp_reg;

    assign k_area   = rd_data[AREA_W-1:0];
    assign k_height = rd_data[OFF_H +: SIZE_W];
    assign k_width  = rd_data[OFF_W +: SIZE_W];
    assign k_top    = $signed(rd_data[OFF_T +: COORD_BITS]);
    assign k_left   = $signed(rd_data[OFF_L +: COORD_BITS]);
    assign wr_data  = {c_left_reg, c_top_reg, c_width_reg, c_height_reg, c_area_reg};

    gbn_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_KEPT),
        .ADDR_W(AW)
    ) u_kept_ram (
        .clk    (clk),
        .wr_en  (load_out & keep_next),
        .wr_addr(kept_count_reg[AW-1:0]),
        .wr_data(wr_data),
        .rd_en  (issue),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                idx_next = '0;
                if (!elig_reg || kept_count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_v_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            iou_thr_reg    <= THR_RESET;
            max_cand_reg   <= MAXC_RESET;
            kept_count_reg <= '0;
            seen_count_reg <= '0;
            elig_reg       <= 1'b0;
            supp_reg       <= 1'b0;
            pipe_v_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pipe_v_reg <= {pipe_v_reg[PIPE_N-2:0], issue};

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_IOU_THRESHOLD:  iou_thr_reg  <= cfg_data[THR_W-1:0];
                    REG_MAX_CANDIDATES: max_cand_reg <= cfg_data[CAND_W-1:0];
                    default:            ;
                endcase
            end

            if (accept)
            begin
                elig_reg <= (seen_count_reg < max_cand_reg)
                          & (kept_count_reg < KCW'(MAX_KEPT));
                supp_reg <= 1'b0;
            end
            else if (pipe_v_reg[PIPE_N-1] && (zero_reg || PROD_W'(lhs_reg) > prod_reg))
            begin
                supp_reg <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (c_fend_reg)
                begin
                    kept_count_reg <= '0;
                    seen_count_reg <= '0;
                end
                else
                begin
                    if (keep_next)
                    begin
                        kept_count_reg <= kept_count_reg + KCW'(1);
                    end
                    if (seen_count_reg != SEEN_SAT)
                    begin
                        seen_count_reg <= seen_count_reg + CAND_W'(1);
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // candidate, compare pipeline and result payload
    assign prod_next = PROD_W'(iou_thr_reg) * PROD_W'(uni_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_left_reg   <= box_left;
            c_top_reg    <= box_top;
            c_width_reg  <= box_width;
            c_height_reg <= box_height;
            c_fend_reg   <= frame_end;
        end
        if (state_reg == ST_AREA)
        begin
            c_area_reg <= AREA_W'(c_width_reg) * AREA_W'(c_height_reg);
        end

        ow_reg     <= overlap(c_left_reg, c_width_reg, k_left, k_width);
        oh_reg     <= overlap(c_top_reg, c_height_reg, k_top, k_height);
        ka1_reg    <= k_area;
        inter_reg  <= INTER_W'(ow_reg) * INTER_W'(oh_reg);
        ka2_reg    <= ka1_reg;
        uni_reg    <= UNI_W'(c_area_reg) + UNI_W'(ka2_reg) - UNI_W'(inter_reg);
        inter3_reg <= inter_reg;
        prod_reg   <= prod_next;
        lhs_reg    <= {inter3_reg, 8'h00};
        zero_reg   <= (uni_reg == '0);

        if (load_out)
        begin
            keep_reg  <= keep_next;
            slot_reg  <= keep_next ? SLOT_W'(kept_count_reg) : '0;
            fdone_reg <= c_fend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign kept_slot  = slot_reg;
    assign frame_done = fdone_reg;

endmodule

`default_nettype wire

/* rtl/core/gbn_checker.sv */
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the box NMS unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_box_nms_unit_macros.svh"

module gbn_checker
    import gbn_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              keep,
    input wire logic [SLOT_W-1:0] kept_slot,
    input wire logic              frame_done
);

    // stalled result holds
    `GBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(keep) && $stable(kept_slot) && $stable(frame_done))

    // suppressed or dropped boxes report slot zero
    `GBN_ASSERT_SAME(a_slot_zero, out_valid && !keep, kept_slot == '0)

    // one candidate at a time: busy right after a transaction
    `GBN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind greedy_box_nms_unit gbn_checker u_gbn_checker (.*);

`default_nettype wire

/* tb/sv/gbn_result_monitor.sv */
// ----------------------------------------------------------------------------
// gbn_result_monitor
// Watches the register port and both channels of the box NMS unit, works out
// the keep/slot/frame_done answer of every accepted candidate from its own
// copy of the kept list and registers, and compares each returned transaction
// against the oldest outstanding answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbn_result_monitor
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] box_left,
    input  logic signed [COORD_BITS-1:0] box_top,
    input  logic        [SIZE_W-1:0]     box_width,
    input  logic        [SIZE_W-1:0]     box_height,
    input  logic                         frame_end,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         keep,
    input  logic        [SLOT_W-1:0]     kept_slot,
    input  logic                         frame_done,
    output int                           errors,
    output int                           verdicts_due,
    output int                           kept_total
);

    typedef logic [AREA_W-1:0] area_t;

    typedef struct packed {
        logic              keep;
        logic [SLOT_W-1:0] slot;
        logic              done;
    } nms_verdict_t;

    nms_verdict_t              pending_verdicts[$];
    logic signed [COORD_BITS-1:0] kept_left [MAX_KEPT];
    logic signed [COORD_BITS-1:0] kept_top  [MAX_KEPT];
    logic        [SIZE_W-1:0]  kept_wid  [MAX_KEPT];
    logic        [SIZE_W-1:0]  kept_hgt  [MAX_KEPT];
    area_t                     kept_area [MAX_KEPT];
    logic        [CAND_W-1:0]  kept_cnt;
    logic        [CAND_W-1:0]  seen_cnt;
    logic        [THR_W-1:0]   iou_thr;
    logic        [CAND_W-1:0]  cand_limit;
    int                        results_seen;

    function automatic longint span_overlap(longint a0, longint alen, longint b0,
                                            longint blen);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // greedy suppression of one candidate against the boxes kept this frame
    function automatic nms_verdict_t judge_box(
        input logic signed [COORD_BITS-1:0] l,
        input logic signed [COORD_BITS-1:0] t,
        input logic        [SIZE_W-1:0]     w,
        input logic        [SIZE_W-1:0]     h,
        input logic                         fe
    );
        nms_verdict_t v;
        area_t        area;
        longint       ow;
        longint       oh;
        longint       inter;
        longint       uni;
        logic         survives;
        area = area_t'(w) * area_t'(h);
        v = '0;
        v.done = fe;
        if (seen_cnt < cand_limit && int'(kept_cnt) < MAX_KEPT)
        begin
            survives = 1'b1;
            for (int k = 0; k < int'(kept_cnt) && survives; k++)
            begin
                ow = span_overlap(longint'(l), longint'(w), longint'(kept_left[k]),
                                  longint'(kept_wid[k]));
                oh = span_overlap(longint'(t), longint'(h), longint'(kept_top[k]),
                                  longint'(kept_hgt[k]));
                inter = (ow > 0 && oh > 0) ? ow * oh : 0;
                uni = longint'(area) + longint'(kept_area[k]) - inter;
                // both boxes empty: union of zero always suppresses
                if (uni == 0 || inter * 256 > longint'(iou_thr) * uni)
                    survives = 1'b0;
            end
            if (survives)
            begin
                kept_left[kept_cnt] = l;
                kept_top[kept_cnt]  = t;
                kept_wid[kept_cnt]  = w;
                kept_hgt[kept_cnt]  = h;
                kept_area[kept_cnt] = area;
                v.keep = 1'b1;
                v.slot = kept_cnt[SLOT_W-1:0];
                kept_cnt = kept_cnt + CAND_W'(1);
            end
        end
        if (seen_cnt != SEEN_SAT)
            seen_cnt = seen_cnt + CAND_W'(1);
        if (fe)
        begin
            kept_cnt = '0;
            seen_cnt = '0;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nms_verdict_t want;
        nms_verdict_t got;
        if (!rst_n)
        begin
            pending_verdicts.delete();
            kept_cnt     = '0;
            seen_cnt     = '0;
            iou_thr      = THR_RESET;
            cand_limit   = MAXC_RESET;
            errors       = 0;
            verdicts_due = 0;
            kept_total   = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{keep: keep, slot: kept_slot, done: frame_done};
                if (pending_verdicts.size() == 0)
                begin
                    if (errors < 10)
                        $display({"nms check: result %0d keep=%0b slot=%0d done=%0b",
                                  " with no candidate outstanding"},
                                 results_seen, got.keep, got.slot, got.done);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want.keep)
                        kept_total++;
                    if (got.keep !== want.keep || got.slot !== want.slot
                        || got.done !== want.done)
                    begin
                        if (errors < 10)
                            $display({"nms check: result %0d expected keep=%0b slot=%0d",
                                      " done=%0b, got keep=%0b slot=%0d done=%0b"},
                                     results_seen, want.keep, want.slot, want.done,
                                     got.keep, got.slot, got.done);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                pending_verdicts.insert(pending_verdicts.size(),
                                        judge_box(box_left, box_top, box_width,
                                                  box_height, frame_end));
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IOU_THRESHOLD:  iou_thr    = cfg_data[THR_W-1:0];
                    REG_MAX_CANDIDATES: cand_limit = cfg_data[CAND_W-1:0];
                    default: ;
                endcase
            end
            verdicts_due = pending_verdicts.size();
        end
    end

endmodule

/* tb/sv/tb_greedy_box_nms_unit.sv */
// ----------------------------------------------------------------------------
// tb_greedy_box_nms_unit
// Drives candidate boxes and register settings into the box NMS unit with
// random idle on both channels; a result monitor beside the unit predicts
// and checks every returned transaction. Directed corner boxes first, then
// clustered, scattered and degenerate frames, a list-filling frame and a
// frame long enough to saturate the per-frame candidate count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_box_nms_unit;
    import gbn_pkg::*;

    localparam int ITEM_TARGET   = 800;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_TAIL      = 80;

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
    typedef logic        [SIZE_W-1:0]         span_t;
    typedef logic        [THR_W-1:0]          thr_t;
    typedef logic        [CAND_W-1:0]         cand_t;

    typedef enum logic [1:0] {SHAPE_CLUSTER, SHAPE_SCATTER, SHAPE_FLAT} box_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    coord_t                box_left;
    coord_t                box_top;
    span_t                 box_width;
    span_t                 box_height;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_ready;
    logic                  keep;
    logic [SLOT_W-1:0]     kept_slot;
    logic                  frame_done;

    int   errors;
    int   verdicts_due;
    int   kept_total;
    int   sent;
    int   frames;
    int   settings;
    int   stale_cycles;
    logic tx_calm;
    logic rx_calm;

    greedy_box_nms_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .keep       (keep),
        .kept_slot  (kept_slot),
        .frame_done (frame_done)
    );

    gbn_result_monitor i_monitor (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver: random stall ahead of every result transaction
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : int'($urandom_range(0, 13));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stale_cycles <= 0;
        else if (stale_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("greedy_box_nms_unit: mismatch");
            $finish;
        end
        else
            stale_cycles <= stale_cycles + 1;
    end

    task automatic send_box(input coord_t l, input coord_t t, input span_t w, input span_t h,
                            input logic fe);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        box_left   <= l;
        box_top    <= t;
        box_width  <= w;
        box_height <= h;
        frame_end  <= fe;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (fe)
            frames++;
    endtask

    // hold off until every result is back and the unit is idle
    task automatic settle(input int tail);
        in_valid <= 1'b0;
        do @(posedge clk); while (verdicts_due != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_limits(input thr_t thr, input cand_t cand);
        cfg_write <= 1'b1;
        cfg_index <= REG_IOU_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_MAX_CANDIDATES;
        cfg_data  <= {{(CFG_DATA_W - CAND_W){1'b0}}, cand};
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic random_frame(input int len, input box_shape_t shape);
        int     cx;
        int     cy;
        int     bw;
        int     bh;
        coord_t l;
        coord_t t;
        span_t  w;
        span_t  h;
        cx = int'($urandom_range(0, 8191)) - 4096;
        cy = int'($urandom_range(0, 8191)) - 4096;
        bw = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095))
                                          : int'($urandom_range(0, 48));
        bh = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095))
                                          : int'($urandom_range(0, 48));
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_SCATTER:
                begin
                    l = coord_t'($urandom());
                    t = coord_t'($urandom());
                    w = span_t'($urandom());
                    h = span_t'($urandom());
                end
                SHAPE_FLAT:
                begin
                    l = coord_t'(cx + int'($urandom_range(0, 3)));
                    t = coord_t'(cy + int'($urandom_range(0, 3)));
                    w = span_t'($urandom_range(0, 6));
                    h = span_t'($urandom_range(0, 6));
                    if ($urandom_range(0, 1) == 0)
                        w = '0;
                    else
                        h = '0;
                end
                default:
                begin
                    l = coord_t'(cx + int'($urandom_range(0, 16)) - 8);
                    t = coord_t'(cy + int'($urandom_range(0, 16)) - 8);
                    w = span_t'(bw + int'($urandom_range(0, 8)));
                    h = span_t'(bh + int'($urandom_range(0, 8)));
                    if ($urandom_range(0, 15) == 0)
                        w = '0;
                end
            endcase
            send_box(l, t, w, h, i == len - 1);
        end
    endtask

    // 70 disjoint boxes: runs past a full list or past the candidate limit
    task automatic grid_frame();
        int ox;
        int oy;
        ox = int'($urandom_range(0, 3000)) - 2048;
        oy = int'($urandom_range(0, 3000)) - 2048;
        for (int i = 0; i < 70; i++)
            send_box(coord_t'(ox + (i % 10) * 24), coord_t'(oy + (i / 10) * 24),
                     span_t'($urandom_range(16, 23)), span_t'($urandom_range(16, 23)),
                     i == 69);
    endtask

    // one box, 130 copies of it, then fresh boxes once the seen count saturates
    task automatic echo_frame();
        coord_t al;
        coord_t at;
        span_t  aw;
        span_t  ah;
        al = coord_t'(int'($urandom_range(0, 2000)) - 1000);
        at = coord_t'(int'($urandom_range(0, 2000)) - 1000);
        aw = span_t'($urandom_range(20, 40));
        ah = span_t'($urandom_range(20, 40));
        for (int i = 0; i < 131; i++)
            send_box(al, at, aw, ah, 1'b0);
        for (int i = 0; i < 4; i++)
            send_box(coord_t'(int'(al) + 100 * (i + 1)), at, aw, ah, i == 3);
    endtask

    initial
    begin
        thr_t       thr;
        cand_t      cand;
        box_shape_t shape;
        int         pick;
        int         stop;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_IOU_THRESHOLD;
        cfg_data   = '0;
        in_valid   = 1'b0;
        box_left   = '0;
        box_top    = '0;
        box_width  = '0;
        box_height = '0;
        frame_end  = 1'b0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        sent       = 0;
        frames     = 0;
        settings   = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: threshold half, 64 candidates
        send_box(0, 0, 10, 10, 1'b0);
        send_box(0, 0, 10, 10, 1'b0);
        send_box(0, 0, 10, 20, 1'b0);
        send_box(10, 0, 10, 10, 1'b0);
        send_box(3, 0, 10, 10, 1'b0);
        send_box(200, 200, 0, 7, 1'b0);
        send_box(500, 500, 9, 0, 1'b0);
        send_box(-4096, -4096, 4095, 4095, 1'b0);
        send_box(4095, 4095, 4095, 4095, 1'b0);
        send_box(-4096, -4096, 4095, 4095, 1'b0);
        send_box(-1, -1, 4095, 4095, 1'b1);
        send_box(0, 0, 10, 10, 1'b0);
        send_box(0, 0, 0, 0, 1'b0);
        send_box(0, 0, 0, 0, 1'b1);
        send_box(2047, -2048, 4095, 0, 1'b1);
        settle(SETTLE_CYCLES);

        for (int phase = 1; sent < ITEM_TARGET; phase++)
        begin
            case (phase)
                1:
                begin
                    thr = '0;
                    cand = cand_t'(64);
                end
                2:
                begin
                    thr = '1;
                    cand = '1;
                end
                3:
                begin
                    thr = thr_t'(256);
                    cand = '0;
                end
                4:
                begin
                    thr = thr_t'(255);
                    cand = cand_t'(1);
                end
                5:
                begin
                    thr = thr_t'(100);
                    cand = '1;
                end
                6:
                begin
                    thr = thr_t'(1);
                    cand = cand_t'(64);
                end
                default:
                begin
                    thr = thr_t'($urandom_range(0, 511));
                    cand = ($urandom_range(0, 3) == 0) ? cand_t'($urandom_range(65, 127))
                                                       : cand_t'($urandom_range(1, 64));
                end
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            set_limits(thr, cand);
            if (phase == 2 || phase == 6)
                grid_frame();
            if (phase == 5)
                echo_frame();
            stop = sent + ((phase == 3) ? 10 : 60);
            while (sent < stop)
            begin
                pick = int'($urandom_range(0, 19));
                shape = (pick < 14) ? SHAPE_CLUSTER
                      : (pick < 17) ? SHAPE_SCATTER : SHAPE_FLAT;
                random_frame(int'($urandom_range(1, 24)), shape);
            end
            settle(SETTLE_CYCLES);
        end
        settle(END_TAIL);

        $display("ran %0d candidates in %0d frames under %0d register settings",
                 sent, frames, settings);
        $display("%0d boxes kept, %0d result errors", kept_total, errors);
        if (errors == 0 && verdicts_due == 0)
            $display("greedy_box_nms_unit: match");
        else
            $display("greedy_box_nms_unit: mismatch");
        $finish;
    end

endmodule
